// ----- rtl/core/gcdist_pkg.sv -----
// Package for the great-circle distance core: widths, fixed-point constants
// and the CORDIC arctangent table.
// No dependencies.
package gcdist_pkg;

    // Default fraction bits of the degree inputs
    localparam int ANGLE_FRAC_BITS_DEF = 20;

    // Fixed widths
    localparam int SAT_W    = 34;   // signed width for saturation and differences
    localparam int RAD_W    = 40;   // scaled radian numerator before divide by 180
    localparam int Q_W      = 31;   // unsigned Q30 value including 1.0
    localparam int CRD_W    = 34;   // signed CORDIC x, y, z
    localparam int SQ_W     = 62;   // square-root remainder and root
    localparam int DIST_W   = 26;
    localparam int RADIUS_W = 24;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;

    // Constants (Q30 where relevant)
    localparam logic [31:0]        PI_Q       = 32'd3373259426;
    localparam logic [Q_W-1:0]     HALF_PI_Q  = 31'd1686629713;
    localparam logic [Q_W-1:0]     Q30_ONE    = 31'd1073741824;
    localparam logic [CRD_W-1:0]   GAIN_INV   = 34'd652032874;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd1630976;
    // floor(2^40 / 180): reciprocal for the divide by 180
    localparam logic [32:0]        DIV180_M   = 33'd6108397932;
    localparam int                 DIV180_SH  = 40;

    // CORDIC arctangent of 2^-i, Q30
    function automatic logic [CRD_W-1:0] atan_q30(input logic [4:0] idx);
        logic [CRD_W-1:0] a;
        case (idx)
            5'd0:  a = 34'h03243F6A8;
            5'd1:  a = 34'h01DAC6705;
            5'd2:  a = 34'h00FADBAFC;
            5'd3:  a = 34'h007F56EA6;
            5'd4:  a = 34'h003FEAB76;
            5'd5:  a = 34'h001FFD55B;
            5'd6:  a = 34'h000FFFAAA;
            5'd7:  a = 34'h0007FFF55;
            5'd8:  a = 34'h0003FFFEA;
            5'd9:  a = 34'h0001FFFFD;
            5'd10: a = 34'h0000FFFFF;
            5'd11: a = 34'h00007FFFF;
            5'd12: a = 34'h00003FFFF;
            5'd13: a = 34'h00001FFFF;
            5'd14: a = 34'h00000FFFF;
            5'd15: a = 34'h000007FFF;
            5'd16: a = 34'h000003FFF;
            5'd17: a = 34'h000001FFF;
            5'd18: a = 34'h000000FFF;
            5'd19: a = 34'h0000007FF;
            5'd20: a = 34'h0000003FF;
            5'd21: a = 34'h0000001FF;
            5'd22: a = 34'h0000000FF;
            5'd23: a = 34'h00000007F;
            5'd24: a = 34'h00000003F;
            5'd25: a = 34'h00000001F;
            5'd26: a = 34'h00000000F;
            5'd27: a = 34'h000000008;
            5'd28: a = 34'h000000004;
            5'd29: a = 34'h000000002;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/core/great_circle_distance_core.sv -----
// Great-circle distance core: haversine formula on a fixed-point pipeline.
// Depends on gcdist_pkg.
//
//  channel  | signals                               | role
//  ---------+---------------------------------------+-----------------------------
//  in       | in_valid, in_ready, lat_a..lon_b      | one point pair per item
//  out      | out_valid, out_ready, distance        | distance in 1/256 km per item
//  cfg      | cfg_valid, cfg_ready, cfg_data        | earth radius write
//
// One item enters per cycle while the output is taken or the last stage is empty;
// each item passes the two 30-step CORDIC pipelines and the two 31-step square roots.
// Reset clears the valid chain and loads the default radius.
// When the output item is not taken, the whole pipeline holds, bubbles
// included; no item is dropped or repeated.
module great_circle_distance_core #(
    parameter int ANGLE_FRAC_BITS = gcdist_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [27:0] lat_a,
    input  logic signed [28:0] lon_a,
    input  logic signed [27:0] lat_b,
    input  logic signed [28:0] lon_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [25:0]        distance,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data
);

    localparam int AF  = ANGLE_FRAC_BITS;
    localparam int SW  = gcdist_pkg::SAT_W;
    localparam int MW  = AF + 9;
    localparam int PW  = MW + 32;
    localparam int TW  = gcdist_pkg::RAD_W;
    localparam int QW  = gcdist_pkg::Q_W;
    localparam int CW  = gcdist_pkg::CRD_W;
    localparam int NW  = gcdist_pkg::SQ_W;
    localparam int RW  = gcdist_pkg::RADIUS_W;
    localparam int DW  = gcdist_pkg::DIST_W;
    localparam int CS  = gcdist_pkg::CORDIC_STEPS;
    localparam int SQ  = gcdist_pkg::SQRT_STEPS;
    localparam int MPW = TW + 33;
    localparam int APW = QW + RW;

    localparam int DEPTH    = 6 + CS + 4 + SQ + 2 + SQ + 1 + CS + 2;
    localparam int SQ1_LAST = 6 + CS + 4 + SQ - 1;
    localparam int VEC_LAST = DEPTH - 3;

    localparam logic signed [SW-1:0] LAT_LIM = SW'(90) <<< AF;
    localparam logic signed [SW-1:0] LON_LIM = SW'(180) <<< AF;
    localparam logic [SW-1:0]        QUARTER = SW'(180) << AF;

    // ------------------------------------------------------------------
    // Helpers
    function automatic logic signed [SW-1:0] sat_fn(input logic signed [SW-1:0] v,
                                                    input logic signed [SW-1:0] lim);
        logic signed [SW-1:0] r;
        if (v > lim)
            r = lim;
        else if (v < -lim)
            r = -lim;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [SW-1:0] abs_fn(input logic signed [SW-1:0] v);
        logic [SW-1:0] r;
        r = (v < 0) ? SW'(-v) : SW'(v);
        return r;
    endfunction

    function automatic logic [QW-1:0] clamp_q(input logic signed [CW-1:0] v,
                                              input logic [QW-1:0] hi);
        logic [QW-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > signed'(CW'(hi)))
            r = hi;
        else
            r = QW'(v);
        return r;
    endfunction

    function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [2*QW-1:0] pr;
        pr = (2*QW)'(a) * (2*QW)'(b) + ((2*QW)'(1) << 29);
        return QW'(pr >> 30);
    endfunction

    // ------------------------------------------------------------------
    // Handshake and valid chain
    logic             en;
    logic [DEPTH-1:0] vld_reg;
    logic [RW-1:0]    radius_reg;

    assign en        = out_ready | ~vld_reg[DEPTH-1];
    assign in_ready  = en;
    assign out_valid = vld_reg[DEPTH-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            radius_reg <= gcdist_pkg::RADIUS_RESET;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
            if (cfg_valid)
                radius_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: saturate coordinates (0 lat_a, 1 lon_a, 2 lat_b, 3 lon_b)
    logic signed [SW-1:0] sat_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0] <= sat_fn(SW'(lat_a), LAT_LIM);
            sat_reg[1] <= sat_fn(SW'(lon_a), LON_LIM);
            sat_reg[2] <= sat_fn(SW'(lat_b), LAT_LIM);
            sat_reg[3] <= sat_fn(SW'(lon_b), LON_LIM);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitudes; lanes 0/1 latitudes, 2 dlat, 3 dlon (folded)
    logic [MW-1:0] mag_reg [4];
    logic [SW-1:0] dlat_mag;
    logic [SW-1:0] dlon_mag;
    logic [SW-1:0] dlon_fold;

    always_comb
    begin
        dlat_mag  = abs_fn(sat_reg[0] - sat_reg[2]);
        dlon_mag  = abs_fn(sat_reg[1] - sat_reg[3]);
        dlon_fold = (dlon_mag > QUARTER) ? ((QUARTER << 1) - dlon_mag) : dlon_mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0] <= MW'(abs_fn(sat_reg[0]));
            mag_reg[1] <= MW'(abs_fn(sat_reg[2]));
            mag_reg[2] <= MW'(dlat_mag);
            mag_reg[3] <= MW'(dlon_fold);
        end
    end

    // ------------------------------------------------------------------
    // Stages 3-6: degrees to Q30 radians, round(mag * pi / (180 * 2^s))
    logic [PW-1:0]      p_reg  [4];
    logic [TW-1:0]      t_reg  [4];
    logic [MPW-1:0]     m_reg  [4];
    logic [TW-1:0]      t5_reg [4];
    logic signed [CW-1:0] rx_reg [CS+1][4];
    logic signed [CW-1:0] ry_reg [CS+1][4];
    logic signed [CW-1:0] rz_reg [CS+1][4];

    for (genvar l = 0; l < 4; l++)
    begin : g_conv
        localparam int S = (l < 2) ? AF : AF + 1;
        logic [32:0] qe;
        logic [TW:0] rem;
        logic [32:0] zq;

        always_comb
        begin
            qe  = m_reg[l][MPW-1:gcdist_pkg::DIV180_SH];
            rem = {1'b0, t5_reg[l]} - (TW+1)'(qe * 33'd180);
            zq  = (rem >= (TW+1)'(180)) ? qe + 33'd1 : qe;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[l]      <= PW'(mag_reg[l]) * PW'(gcdist_pkg::PI_Q);
                t_reg[l]      <= TW'((p_reg[l] + (PW'(90) << S)) >> S);
                m_reg[l]      <= MPW'(t_reg[l]) * MPW'(gcdist_pkg::DIV180_M);
                t5_reg[l]     <= t_reg[l];
                rx_reg[0][l]  <= signed'(gcdist_pkg::GAIN_INV);
                ry_reg[0][l]  <= '0;
                rz_reg[0][l]  <= signed'(CW'(zq));
            end
        end
    end

    // ------------------------------------------------------------------
    // Rotation CORDIC: 30 stages, four lanes
    for (genvar k = 0; k < CS; k++)
    begin : g_rot
        for (genvar l = 0; l < 4; l++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rz_reg[k][l] >= 0)
                    begin
                        rx_reg[k+1][l] <= rx_reg[k][l] - (ry_reg[k][l] >>> k);
                        ry_reg[k+1][l] <= ry_reg[k][l] + (rx_reg[k][l] >>> k);
                        rz_reg[k+1][l] <= rz_reg[k][l] - signed'(gcdist_pkg::atan_q30(5'(k)));
                    end
                    else
                    begin
                        rx_reg[k+1][l] <= rx_reg[k][l] + (ry_reg[k][l] >>> k);
                        ry_reg[k+1][l] <= ry_reg[k][l] - (rx_reg[k][l] >>> k);
                        rz_reg[k+1][l] <= rz_reg[k][l] + signed'(gcdist_pkg::atan_q30(5'(k)));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Haversine sum: clamp, products, add and clamp to one
    logic [QW-1:0] cl_reg [4];
    logic [QW-1:0] cc_reg;
    logic [QW-1:0] sl_reg;
    logic [QW-1:0] so_reg;
    logic [QW-1:0] tp_reg;
    logic [QW-1:0] sl3_reg;
    logic [QW:0]   h_sum;
    logic [QW-1:0] h_cl;

    always_comb
    begin
        h_sum = (QW+1)'(tp_reg) + (QW+1)'(sl3_reg);
        h_cl  = (h_sum > (QW+1)'(gcdist_pkg::Q30_ONE)) ? gcdist_pkg::Q30_ONE : QW'(h_sum);
    end

    logic [NW-1:0] sn_reg [SQ+1];
    logic [NW-1:0] sr_reg [SQ+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cl_reg[0]  <= clamp_q(rx_reg[CS][0], gcdist_pkg::Q30_ONE);
            cl_reg[1]  <= clamp_q(rx_reg[CS][1], gcdist_pkg::Q30_ONE);
            cl_reg[2]  <= clamp_q(ry_reg[CS][2], gcdist_pkg::Q30_ONE);
            cl_reg[3]  <= clamp_q(ry_reg[CS][3], gcdist_pkg::Q30_ONE);
            cc_reg     <= qmul(cl_reg[0], cl_reg[1]);
            sl_reg     <= qmul(cl_reg[2], cl_reg[2]);
            so_reg     <= qmul(cl_reg[3], cl_reg[3]);
            tp_reg     <= qmul(cc_reg, so_reg);
            sl3_reg    <= sl_reg;
            sn_reg[0]  <= NW'(h_cl) << 30;
            sr_reg[0]  <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Square root of h * 2^30, one result bit per stage
    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt1
        localparam logic [NW-1:0] BIT = NW'(1) << (2*(SQ-1-k));
        logic [NW-1:0] trial;

        assign trial = sr_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sn_reg[k] >= trial)
                begin
                    sn_reg[k+1] <= sn_reg[k] - trial;
                    sr_reg[k+1] <= (sr_reg[k] >> 1) + BIT;
                end
                else
                begin
                    sn_reg[k+1] <= sn_reg[k];
                    sr_reg[k+1] <= sr_reg[k] >> 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // q squared, then sqrt(2^60 - q^2) with q carried alongside
    logic [QW-1:0]   q1_reg;
    logic [2*QW-1:0] qq_reg;
    logic [QW-1:0]   q_cl;
    logic [NW-1:0]   tn_reg [SQ+1];
    logic [NW-1:0]   tr_reg [SQ+1];
    logic [QW-1:0]   cq_reg [SQ+1];

    assign q_cl = (sr_reg[SQ] > NW'(gcdist_pkg::Q30_ONE)) ? gcdist_pkg::Q30_ONE
                                                          : QW'(sr_reg[SQ]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg    <= q_cl;
            qq_reg    <= (2*QW)'(q_cl) * (2*QW)'(q_cl);
            tn_reg[0] <= (NW'(1) << 60) - NW'(qq_reg);
            tr_reg[0] <= '0;
            cq_reg[0] <= q1_reg;
        end
    end

    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt2
        localparam logic [NW-1:0] BIT = NW'(1) << (2*(SQ-1-k));
        logic [NW-1:0] trial;

        assign trial = tr_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cq_reg[k+1] <= cq_reg[k];
                if (tn_reg[k] >= trial)
                begin
                    tn_reg[k+1] <= tn_reg[k] - trial;
                    tr_reg[k+1] <= (tr_reg[k] >> 1) + BIT;
                end
                else
                begin
                    tn_reg[k+1] <= tn_reg[k];
                    tr_reg[k+1] <= tr_reg[k] >> 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Vectoring CORDIC on (w, q): arcsine of q
    logic signed [CW-1:0] vx_reg [CS+1];
    logic signed [CW-1:0] vy_reg [CS+1];
    logic signed [CW-1:0] vz_reg [CS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg[0] <= signed'(CW'(tr_reg[SQ]));
            vy_reg[0] <= signed'(CW'(cq_reg[SQ]));
            vz_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < CS; k++)
    begin : g_vec
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (vy_reg[k] > 0)
                begin
                    vx_reg[k+1] <= vx_reg[k] + (vy_reg[k] >>> k);
                    vy_reg[k+1] <= vy_reg[k] - (vx_reg[k] >>> k);
                    vz_reg[k+1] <= vz_reg[k] + signed'(gcdist_pkg::atan_q30(5'(k)));
                end
                else
                begin
                    vx_reg[k+1] <= vx_reg[k] - (vy_reg[k] >>> k);
                    vy_reg[k+1] <= vy_reg[k] + (vx_reg[k] >>> k);
                    vz_reg[k+1] <= vz_reg[k] - signed'(gcdist_pkg::atan_q30(5'(k)));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Distance: 2 * angle * radius in Q30, rounded
    logic [APW-1:0] ap_reg;
    logic [DW-1:0]  dist_reg;
    logic [APW:0]   ap_round;

    assign ap_round = (APW+1)'(ap_reg) + ((APW+1)'(1) << 28);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ap_reg   <= APW'(clamp_q(vz_reg[CS], gcdist_pkg::HALF_PI_Q)) * APW'(radius_reg);
            dist_reg <= DW'(ap_round >> 29);
        end
    end

    assign distance = dist_reg;

    // ------------------------------------------------------------------
    // Checks
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dist_reg) && $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQ1_LAST] |-> sr_reg[SQ] <= NW'(gcdist_pkg::Q30_ONE))
        else $error("square root of haversine exceeds one");

    a_vec_pos: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[VEC_LAST] |-> vx_reg[CS] > 0)
        else $error("vectoring CORDIC left the right half plane");

endmodule
